// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_ALWAYS(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed: expression does not hold");

`define ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_ALWAYS(lbl, clk, rst, expr)

`define ASSERT_IMPLY(lbl, clk, rst, ante, cons)

`define ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

// File: rtl/epcs_pkg.sv
// ----------------------------------------------------------------------------
// epcs_pkg
// Types and constants of the encoder pulse counter and speed unit.
// ----------------------------------------------------------------------------
`default_nettype none

package epcs_pkg;

   localparam int COUNT_WIDTH_DEFAULT = 32;
   localparam int TIME_WIDTH          = 32;
   localparam int VALUE_WIDTH         = 32;
   localparam int LINES_WIDTH         = 16;
   localparam int OPCODE_WIDTH        = 3;
   localparam int SPEED_WIDTH         = 20;
   localparam int DIV_STEPS           = SPEED_WIDTH;
   localparam int CSR_INDEX_WIDTH     = 1;
   localparam int CSR_DATA_WIDTH      = 32;

   localparam logic [SPEED_WIDTH-1:0] SPEED_NUMERATOR = 20'd1000000;
   localparam logic [TIME_WIDTH-1:0]  LOCKOUT_RESET   = 32'd25000;
   localparam logic [LINES_WIDTH-1:0] LINES_RESET     = 16'd1;

   typedef enum logic [OPCODE_WIDTH-1:0] {
      OP_PULSE      = 3'd0,
      OP_READ_TOTAL = 3'd1,
      OP_READ_DELTA = 3'd2,
      OP_PEEK_DELTA = 3'd3,
      OP_READ_SPEED = 3'd4,
      OP_CLEAR      = 3'd5
   } epcs_op_type;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_DISK_LINES = 1'b0,
      CSR_LOCKOUT_US = 1'b1
   } epcs_csr_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_DIV_LINES,
      ST_DIV_RESTART,
      ST_DIV_TIME,
      ST_STORE,
      ST_DONE
   } epcs_state_type;

   typedef struct packed {
      logic [OPCODE_WIDTH-1:0] opcode;
      logic [TIME_WIDTH-1:0]   timestamp_us;
   } epcs_req_type;

   typedef struct packed {
      logic [VALUE_WIDTH-1:0] read_value;
      logic                   pulse_accepted;
   } epcs_rsp_type;

   typedef struct packed {
      logic load;
      logic exec;
      logic div_start_lines;
      logic div_start_time;
      logic div_step;
      logic speed_store;
      logic rsp_load;
   } epcs_cmd_type;

   typedef struct packed {
      logic pulse_hit;
      logic div_last;
      logic rsp_free;
   } epcs_sts_type;

endpackage

`default_nettype wire

// File: rtl/epcs_ctrl.sv
// ----------------------------------------------------------------------------
// epcs_ctrl
// Sequencer: request intake, command execution, two serial divisions, response.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module epcs_ctrl
   import epcs_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  epcs_sts_type sts,
   output epcs_cmd_type cmd
);

   epcs_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.exec = 1'b1;
            if (sts.pulse_hit) begin
               cmd.div_start_lines = 1'b1;
               state_in            = ST_DIV_LINES;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_DIV_LINES: begin
            cmd.div_step = 1'b1;
            if (sts.div_last) begin
               state_in = ST_DIV_RESTART;
            end
         end
         ST_DIV_RESTART: begin
            cmd.div_start_time = 1'b1;
            state_in           = ST_DIV_TIME;
         end
         ST_DIV_TIME: begin
            cmd.div_step = 1'b1;
            if (sts.div_last) begin
               state_in = ST_STORE;
            end
         end
         ST_STORE: begin
            cmd.speed_store = 1'b1;
            state_in        = ST_DONE;
         end
         ST_DONE: begin
            if (sts.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   `ASSERT_NEXT(a_miss_goes_done, clock, reset, (state_ff == ST_EXEC) && !sts.pulse_hit, state_ff == ST_DONE)
   `ASSERT_NEXT(a_first_div_ends, clock, reset, (state_ff == ST_DIV_LINES) && sts.div_last, state_ff == ST_DIV_RESTART)

endmodule

`default_nettype wire

// File: rtl/epcs_dp.sv
// ----------------------------------------------------------------------------
// epcs_dp
// Datapath: config registers, counters, serial restoring divider, response reg.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module epcs_dp
   import epcs_pkg::*;
#(
   parameter int COUNT_WIDTH = COUNT_WIDTH_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_we,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_wdata,
   input  epcs_req_type               req_data,
   input  logic                       rsp_ready,
   input  epcs_cmd_type               cmd,
   output epcs_sts_type               sts,
   output logic                       rsp_valid,
   output epcs_rsp_type               rsp_data
);

   localparam int DivCntW = $clog2(DIV_STEPS);

   logic [LINES_WIDTH-1:0]  lines_ff, lines_in;
   logic [TIME_WIDTH-1:0]   lockout_ff, lockout_in;
   logic [OPCODE_WIDTH-1:0] op_ff, op_in;
   logic [TIME_WIDTH-1:0]   ts_ff, ts_in;
   logic [TIME_WIDTH-1:0]   elapsed_ff, elapsed_in;
   logic [TIME_WIDTH-1:0]   last_ff, last_in;
   logic [COUNT_WIDTH-1:0]  total_ff, total_in;
   logic [COUNT_WIDTH-1:0]  delta_ff, delta_in;
   logic [SPEED_WIDTH-1:0]  speed_ff, speed_in;
   logic [TIME_WIDTH-1:0]   div_rem_ff, div_rem_in;
   logic [SPEED_WIDTH-1:0]  div_quo_ff, div_quo_in;
   logic [TIME_WIDTH-1:0]   div_dvs_ff, div_dvs_in;
   logic [DivCntW-1:0]      div_cnt_ff, div_cnt_in;
   epcs_rsp_type            res_ff, res_in;
   epcs_rsp_type            rsp_ff, rsp_in;
   logic                    rsp_valid_ff, rsp_valid_in;

   logic [TIME_WIDTH:0] div_shift;
   logic [TIME_WIDTH:0] div_diff;
   logic                pulse_hit;

   assign div_shift = {div_rem_ff, div_quo_ff[SPEED_WIDTH-1]};
   assign div_diff  = div_shift - {1'b0, div_dvs_ff};
   assign pulse_hit = (op_ff == OP_PULSE) && (elapsed_ff >= lockout_ff);

   assign sts.pulse_hit = pulse_hit;
   assign sts.div_last  = (div_cnt_ff == DivCntW'(DIV_STEPS - 1));
   assign sts.rsp_free  = !rsp_valid_ff || rsp_ready;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      lines_in     = lines_ff;
      lockout_in   = lockout_ff;
      op_in        = op_ff;
      ts_in        = ts_ff;
      elapsed_in   = elapsed_ff;
      last_in      = last_ff;
      total_in     = total_ff;
      delta_in     = delta_ff;
      speed_in     = speed_ff;
      div_rem_in   = div_rem_ff;
      div_quo_in   = div_quo_ff;
      div_dvs_in   = div_dvs_ff;
      div_cnt_in   = div_cnt_ff;
      res_in       = res_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;

      if (csr_we) begin
         case (csr_index)
            CSR_DISK_LINES: lines_in   = csr_wdata[LINES_WIDTH-1:0];
            CSR_LOCKOUT_US: lockout_in = csr_wdata[TIME_WIDTH-1:0];
            default: begin
            end
         endcase
      end

      if (cmd.load) begin
         op_in      = req_data.opcode;
         ts_in      = req_data.timestamp_us;
         elapsed_in = req_data.timestamp_us - last_ff;
      end

      if (cmd.exec) begin
         res_in = '0;
         case (op_ff)
            OP_PULSE: begin
               if (pulse_hit) begin
                  last_in               = ts_ff;
                  total_in              = total_ff + COUNT_WIDTH'(1);
                  delta_in              = delta_ff + COUNT_WIDTH'(1);
                  res_in.pulse_accepted = 1'b1;
               end
            end
            OP_READ_TOTAL: begin
               res_in.read_value = VALUE_WIDTH'(total_ff);
               delta_in          = '0;
            end
            OP_READ_DELTA: begin
               res_in.read_value = VALUE_WIDTH'(delta_ff);
               delta_in          = '0;
            end
            OP_PEEK_DELTA: begin
               res_in.read_value = VALUE_WIDTH'(delta_ff);
            end
            OP_READ_SPEED: begin
               res_in.read_value = VALUE_WIDTH'(speed_ff);
            end
            OP_CLEAR: begin
               total_in = '0;
               delta_in = '0;
               speed_in = '0;
            end
            default: begin
            end
         endcase
      end

      // 1000000 / lines, zero lines taken as one
      if (cmd.div_start_lines) begin
         div_rem_in = '0;
         div_quo_in = SPEED_NUMERATOR;
         div_cnt_in = '0;
         div_dvs_in = (lines_ff == '0) ? TIME_WIDTH'(1) : TIME_WIDTH'(lines_ff);
      end

      // quotient / elapsed, zero elapsed taken as one
      if (cmd.div_start_time) begin
         div_rem_in = '0;
         div_cnt_in = '0;
         div_dvs_in = (elapsed_ff == '0) ? TIME_WIDTH'(1) : elapsed_ff;
      end

      if (cmd.div_step) begin
         div_cnt_in = div_cnt_ff + DivCntW'(1);
         if (!div_diff[TIME_WIDTH]) begin
            div_rem_in = div_diff[TIME_WIDTH-1:0];
            div_quo_in = {div_quo_ff[SPEED_WIDTH-2:0], 1'b1};
         end else begin
            div_rem_in = div_shift[TIME_WIDTH-1:0];
            div_quo_in = {div_quo_ff[SPEED_WIDTH-2:0], 1'b0};
         end
      end

      if (cmd.speed_store) begin
         speed_in = div_quo_ff;
      end

      if (cmd.rsp_load) begin
         rsp_in       = res_ff;
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lines_ff     <= LINES_RESET;
         lockout_ff   <= LOCKOUT_RESET;
         last_ff      <= '0;
         total_ff     <= '0;
         delta_ff     <= '0;
         speed_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         lines_ff     <= lines_in;
         lockout_ff   <= lockout_in;
         last_ff      <= last_in;
         total_ff     <= total_in;
         delta_ff     <= delta_in;
         speed_ff     <= speed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff      <= op_in;
      ts_ff      <= ts_in;
      elapsed_ff <= elapsed_in;
      div_rem_ff <= div_rem_in;
      div_quo_ff <= div_quo_in;
      div_dvs_ff <= div_dvs_in;
      div_cnt_ff <= div_cnt_in;
      res_ff     <= res_in;
      rsp_ff     <= rsp_in;
   end

   `ASSERT_IMPLY(a_rsp_no_overwrite, clock, reset, cmd.rsp_load, !rsp_valid_ff || rsp_ready)
   `ASSERT_IMPLY(a_pulse_reads_zero, clock, reset, rsp_valid_ff && rsp_ff.pulse_accepted, rsp_ff.read_value == '0)
   `ASSERT_IMPLY(a_div_rem_below, clock, reset, cmd.div_step && (div_cnt_ff != '0), div_rem_ff < div_dvs_ff)

endmodule

`default_nettype wire

// File: rtl/encoder_pulse_counter_speed_unit.sv
// ----------------------------------------------------------------------------
// encoder_pulse_counter_speed_unit
// Encoder pulse counter with lockout filter and speed estimate.
// ----------------------------------------------------------------------------
// One request is handled at a time. A counted pulse goes from acceptance to
// response via the execute state, two 20-step passes of a single shared
// restoring divider (1000000 / disk_lines, then by the elapsed time), the
// restart and store states and the response load. Reads, clears and pulses
// rejected by the lockout skip the divider. The response register frees the
// sequencer once loaded; a new request is taken while a response waits.
// Counters wrap at COUNT_WIDTH bits; reads return the low 32 bits.
// ----------------------------------------------------------------------------
`default_nettype none

module encoder_pulse_counter_speed_unit
   import epcs_pkg::*;
#(
   parameter int COUNT_WIDTH = COUNT_WIDTH_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  epcs_req_type               req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output epcs_rsp_type               rsp_data,
   input  logic                       csr_we,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_wdata
);

   epcs_cmd_type cmd;
   epcs_sts_type sts;

   epcs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   epcs_dp #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_data  (req_data),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire
